// ===== rtl/tocc_pkg.sv =====
package tocc_pkg;

	// sizes
	localparam int MAX_NODES = 32;
	localparam int MAX_EDGES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int EDGE_AW   = $clog2(MAX_EDGES);
	localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
	localparam int NCNT_W    = $clog2(MAX_NODES + 1);

	// item codes
	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_SOLVE = 1'b1;
	localparam logic [1:0] REL_LESS    = 2'd0;
	localparam logic [1:0] REL_GREATER = 2'd1;

	// result status codes
	localparam logic [1:0] ST_POSSIBLE   = 2'd0;
	localparam logic [1:0] ST_IMPOSSIBLE = 2'd1;
	localparam logic [1:0] ST_UNKNOWN    = 2'd2;
	localparam logic [1:0] ST_FULL       = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_ROOT,
		S_SCAN,
		S_EVAL,
		S_POP_RD,
		S_POP_LD,
		S_EMIT_RD,
		S_EMIT_WR,
		S_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic add_load;
		logic clr;
		logic root_skip;
		logic root_start;
		logic eval;
		logic finish;
		logic pop_load;
		logic emit_load;
		logic res_load;
		logic res_cycle;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic s_lt_n;
		logic root_fin;
		logic e_lt_cnt;
		logic cycle;
		logic parents_zero;
		logic emit_last;
		logic done_zero;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/tocc_if.sv =====
interface tocc_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [4:0] first_node;
	logic [4:0] second_node;
	logic [1:0] relation;

	modport source (output valid, action, first_node, second_node, relation, input ready);
	modport sink (input valid, action, first_node, second_node, relation, output ready);
endinterface

interface tocc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       has_node;
	logic [4:0] node_id;
	logic       last;

	modport source (output valid, status, has_node, node_id, last, input ready);
	modport sink (input valid, status, has_node, node_id, last, output ready);
endinterface

// ===== rtl/tocc_ctrl.sv =====
module tocc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_action,
	output logic          item_ready,
	input  tocc_pkg::sts_t sts,
	output tocc_pkg::cmd_t cmd
);

	tocc_pkg::state_t state_q, state_d;
	logic res_cycle_q, res_cycle_d;
	logic acc;

	assign item_ready = (state_q == tocc_pkg::S_IDLE) && sts.out_free;
	assign acc        = item_valid && item_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tocc_pkg::S_IDLE;
			res_cycle_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_cycle_q <= res_cycle_d;
		end
	end

	// next state
	always_comb begin
		state_d     = state_q;
		res_cycle_d = res_cycle_q;
		unique case (state_q)
			tocc_pkg::S_IDLE: begin
				if (acc && item_action == tocc_pkg::ACT_SOLVE) state_d = tocc_pkg::S_CLEAR;
			end
			tocc_pkg::S_CLEAR: state_d = tocc_pkg::S_ROOT;
			tocc_pkg::S_ROOT: begin
				if (!sts.s_lt_n) begin
					res_cycle_d = 1'b0;
					state_d = sts.done_zero ? tocc_pkg::S_RESULT : tocc_pkg::S_EMIT_RD;
				end else if (!sts.root_fin) begin
					state_d = tocc_pkg::S_SCAN;
				end
			end
			tocc_pkg::S_SCAN: begin
				if (sts.e_lt_cnt) state_d = tocc_pkg::S_EVAL;
				else if (sts.parents_zero) state_d = tocc_pkg::S_ROOT;
				else state_d = tocc_pkg::S_POP_RD;
			end
			tocc_pkg::S_EVAL: begin
				if (sts.cycle) begin
					res_cycle_d = 1'b1;
					state_d = tocc_pkg::S_RESULT;
				end else begin
					state_d = tocc_pkg::S_SCAN;
				end
			end
			tocc_pkg::S_POP_RD: state_d = tocc_pkg::S_POP_LD;
			tocc_pkg::S_POP_LD: state_d = tocc_pkg::S_SCAN;
			tocc_pkg::S_EMIT_RD: state_d = tocc_pkg::S_EMIT_WR;
			tocc_pkg::S_EMIT_WR: begin
				if (sts.out_free) state_d = sts.emit_last ? tocc_pkg::S_IDLE : tocc_pkg::S_EMIT_RD;
			end
			tocc_pkg::S_RESULT: begin
				if (sts.out_free) state_d = tocc_pkg::S_IDLE;
			end
			default: state_d = tocc_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.res_cycle = res_cycle_q;
		unique case (state_q)
			tocc_pkg::S_IDLE:    cmd.add_load = acc && item_action == tocc_pkg::ACT_ADD;
			tocc_pkg::S_CLEAR:   cmd.clr = 1'b1;
			tocc_pkg::S_ROOT: begin
				cmd.root_skip  = sts.s_lt_n && sts.root_fin;
				cmd.root_start = sts.s_lt_n && !sts.root_fin;
			end
			tocc_pkg::S_SCAN:    cmd.finish = !sts.e_lt_cnt;
			tocc_pkg::S_EVAL:    cmd.eval = 1'b1;
			tocc_pkg::S_POP_RD:  cmd = cmd;
			tocc_pkg::S_POP_LD:  cmd.pop_load = 1'b1;
			tocc_pkg::S_EMIT_RD: cmd = cmd;
			tocc_pkg::S_EMIT_WR: cmd.emit_load = sts.out_free;
			tocc_pkg::S_RESULT:  cmd.res_load = sts.out_free;
			default:             cmd = '0;
		endcase
	end

	// a solve never starts while a result is still being emitted
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> state_q == tocc_pkg::S_IDLE)
		else $error("ready outside idle");
	a_eval_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tocc_pkg::S_EVAL |-> $past(state_q) == tocc_pkg::S_SCAN)
		else $error("eval without edge read");
	a_cycle_only_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tocc_pkg::S_RESULT && res_cycle_q && $changed(state_q))
			|-> $past(state_q) == tocc_pkg::S_EVAL)
		else $error("cycle result not from edge evaluation");

endmodule

// ===== rtl/tocc_dp.sv =====
module tocc_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [4:0]     first_node,
	input  logic [4:0]     second_node,
	input  logic [1:0]     relation,
	input  tocc_pkg::cmd_t cmd,
	output tocc_pkg::sts_t sts,
	tocc_result_if.source  result
);

	localparam int NW = tocc_pkg::NODE_W;
	localparam int EA = tocc_pkg::EDGE_AW;
	localparam int EC = tocc_pkg::ECNT_W;
	localparam int NC = tocc_pkg::NCNT_W;

	// memories
	logic [NW-1:0] src_mem   [tocc_pkg::MAX_EDGES];
	logic [NW-1:0] tgt_mem   [tocc_pkg::MAX_EDGES];
	logic [NW+EC-1:0] stk_mem [tocc_pkg::MAX_NODES];
	logic [NW-1:0] ord_mem   [tocc_pkg::MAX_NODES];

	logic [NW-1:0]    rd_src_q, rd_tgt_q, rd_ord_q;
	logic [NW+EC-1:0] rd_stk_q;

	// control state
	logic [EC-1:0] edge_cnt_q;
	logic [NC-1:0] node_cnt_q;
	logic [tocc_pkg::MAX_NODES-1:0] fin_q, path_q;
	logic [NC-1:0] s_q;
	logic [NW-1:0] cur_v_q;
	logic [EC-1:0] cur_e_q;
	logic [NW-1:0] parents_q;
	logic [NC-1:0] done_q;
	logic [NW-1:0] idx_q;

	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic          out_has_q;
	logic [NW-1:0] out_id_q;
	logic          out_last_q;

	logic          hit, push, full, unknown;
	logic [NC-1:0] a_ext, b_ext;
	logic [1:0]    add_status;

	assign hit     = rd_src_q == cur_v_q;
	assign push    = cmd.eval && hit && !path_q[rd_tgt_q] && !fin_q[rd_tgt_q]
		&& parents_q != NW'(tocc_pkg::MAX_NODES - 1);
	assign full    = edge_cnt_q == EC'(tocc_pkg::MAX_EDGES);
	assign unknown = relation != tocc_pkg::REL_LESS && relation != tocc_pkg::REL_GREATER;
	assign a_ext   = NC'(first_node) + NC'(1);
	assign b_ext   = NC'(second_node) + NC'(1);

	always_comb begin
		if (unknown) add_status = tocc_pkg::ST_UNKNOWN;
		else if (full) add_status = tocc_pkg::ST_FULL;
		else add_status = tocc_pkg::ST_POSSIBLE;
	end

	// status to controller
	assign sts.s_lt_n       = s_q < node_cnt_q;
	assign sts.root_fin     = fin_q[s_q[NW-1:0]];
	assign sts.e_lt_cnt     = cur_e_q < edge_cnt_q;
	assign sts.cycle        = hit && path_q[rd_tgt_q];
	assign sts.parents_zero = parents_q == '0;
	assign sts.emit_last    = NC'(idx_q) + NC'(1) == done_q;
	assign sts.done_zero    = done_q == '0;
	assign sts.out_free     = !out_valid_q || result.ready;

	// edge store
	always_ff @(posedge clk) begin
		if (cmd.add_load && !unknown && !full) begin
			src_mem[edge_cnt_q[EA-1:0]] <= relation == tocc_pkg::REL_LESS ? first_node : second_node;
			tgt_mem[edge_cnt_q[EA-1:0]] <= relation == tocc_pkg::REL_LESS ? second_node : first_node;
		end
		rd_src_q <= src_mem[cur_e_q[EA-1:0]];
		rd_tgt_q <= tgt_mem[cur_e_q[EA-1:0]];
	end

	// search stack and finishing order
	always_ff @(posedge clk) begin
		if (push) stk_mem[parents_q] <= {cur_v_q, cur_e_q + EC'(1)};
		if (cmd.finish) ord_mem[done_q[NW-1:0]] <= cur_v_q;
		rd_stk_q <= stk_mem[parents_q - NW'(1)];
		rd_ord_q <= ord_mem[idx_q];
	end

	// counters, marks and walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q <= '0;
			node_cnt_q <= '0;
			fin_q      <= '0;
			path_q     <= '0;
			s_q        <= '0;
			cur_v_q    <= '0;
			cur_e_q    <= '0;
			parents_q  <= '0;
			done_q     <= '0;
			idx_q      <= '0;
		end else begin
			if (cmd.add_load) begin
				if (a_ext > node_cnt_q || b_ext > node_cnt_q)
					node_cnt_q <= a_ext > b_ext ? a_ext : b_ext;
				if (!unknown && !full) edge_cnt_q <= edge_cnt_q + EC'(1);
			end
			if (cmd.clr) begin
				fin_q     <= '0;
				path_q    <= '0;
				s_q       <= '0;
				done_q    <= '0;
				idx_q     <= '0;
				parents_q <= '0;
			end
			if (cmd.root_skip) s_q <= s_q + NC'(1);
			if (cmd.root_start) begin
				cur_v_q <= s_q[NW-1:0];
				cur_e_q <= '0;
				path_q[s_q[NW-1:0]] <= 1'b1;
			end
			if (cmd.eval) begin
				if (push) begin
					cur_v_q   <= rd_tgt_q;
					cur_e_q   <= '0;
					parents_q <= parents_q + NW'(1);
					path_q[rd_tgt_q] <= 1'b1;
				end else begin
					cur_e_q <= cur_e_q + EC'(1);
				end
			end
			if (cmd.finish) begin
				path_q[cur_v_q] <= 1'b0;
				fin_q[cur_v_q]  <= 1'b1;
				done_q <= done_q + NC'(1);
				if (parents_q == '0) s_q <= s_q + NC'(1);
			end
			if (cmd.pop_load) begin
				cur_v_q   <= rd_stk_q[NW+EC-1:EC];
				cur_e_q   <= rd_stk_q[EC-1:0];
				parents_q <= parents_q - NW'(1);
			end
			if (cmd.emit_load) idx_q <= idx_q + NW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.add_load || cmd.emit_load || cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_load) begin
			out_status_q <= add_status;
			out_has_q    <= 1'b0;
			out_id_q     <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.emit_load) begin
			out_status_q <= tocc_pkg::ST_POSSIBLE;
			out_has_q    <= 1'b1;
			out_id_q     <= rd_ord_q;
			out_last_q   <= sts.emit_last;
		end else if (cmd.res_load) begin
			out_status_q <= cmd.res_cycle ? tocc_pkg::ST_IMPOSSIBLE : tocc_pkg::ST_POSSIBLE;
			out_has_q    <= 1'b0;
			out_id_q     <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.status   = out_status_q;
	assign result.has_node = out_has_q;
	assign result.node_id  = out_id_q;
	assign result.last     = out_last_q;

	a_edge_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		edge_cnt_q <= EC'(tocc_pkg::MAX_EDGES))
		else $error("edge count past store depth");
	a_cur_on_path: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> path_q[cur_v_q])
		else $error("current node not on path");
	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> done_q < NC'(tocc_pkg::MAX_NODES) && !fin_q[cur_v_q])
		else $error("node finished twice");

endmodule

// ===== rtl/topological_order_with_cycle_check.sv =====
// Topological sort with cycle check. An add item (action 0) stores one edge
// from the lesser to the greater node unless the relation is unknown or the
// store is full, and answers with a single registered result; adds can be
// taken back to back while the result is drained. A solve item (action 1)
// runs a depth-first search over nodes 0..node_count-1 using the single read
// port of the 64-entry edge store: an edge examined takes a registered read,
// then an evaluate step; a backtrack a finish, stack read and stack load
// step; a node a start or skip step. Nodes then stream out in finishing order
// (a read then a write step each), or one result on a cycle or empty graph.
module topological_order_with_cycle_check (
	input logic          clk,
	input logic          arst_n,
	tocc_item_if.sink    item,
	tocc_result_if.source result
);

	tocc_pkg::cmd_t cmd;
	tocc_pkg::sts_t sts;

	tocc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_action (item.action),
		.item_ready  (item.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	tocc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.first_node  (item.first_node),
		.second_node (item.second_node),
		.relation    (item.relation),
		.cmd         (cmd),
		.sts         (sts),
		.result      (result)
	);

endmodule
